@@ sv/pva_pkg.sv @@
// shared types and constants of the polyphonic voice allocator
`default_nettype none

package pva_pkg;

  localparam int VOICE_W = 3;
  localparam int TAG_W   = 32;
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int CHAN_W  = 4;
  localparam int MUTE_W  = 24;
  localparam int MAP_W   = 32;
  localparam int CFG_W   = 32;

  localparam logic [MUTE_W-1:0] MUTE_TICKS_RESET = 24'd8820;

  // configuration register indexes
  localparam logic REG_CHANNEL_MAP = 1'b0;
  localparam logic REG_MUTE_TICKS  = 1'b1;

  typedef enum logic [1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_OFF_NOTE = 2'd1,
    KIND_OFF_TAG  = 2'd2,
    KIND_TICK     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_NONE    = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    action_t             action;
    logic [VOICE_W-1:0]  voice;
    logic [TAG_W-1:0]    tag;
    logic [NOTE_W-1:0]   note;
    logic [VEL_W-1:0]    vel;
    logic                last;
  } result_t;

endpackage

`default_nettype wire

@@ sv/pva_out_reg.sv @@
// output register for result transactions
`default_nettype none

module pva_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire pva_pkg::result_t push_res,
  output logic                  can_push,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            action,
  output logic [2:0]            voice,
  output logic [31:0]           voice_tag,
  output logic [6:0]            voice_note,
  output logic [6:0]            out_velocity,
  output logic                  last
);
  import pva_pkg::*;

  result_t held;

  assign can_push = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= push_res;
    end
  end

  assign action       = held.action;
  assign voice        = held.voice;
  assign voice_tag    = held.tag;
  assign voice_note   = held.note;
  assign out_velocity = held.vel;
  assign last         = held.last;

endmodule

`default_nettype wire

@@ sv/polyphonic_voice_allocator.sv @@
// top level of the polyphonic voice allocator with oldest-voice stealing
// an accepted event scans one voice per cycle, held while an earlier release waits on a
//   full output register; a note-on then passes through a commit state to the output register
// a new event is taken only back in the idle state, once the last one is through; result
//   stalls hold the commit and flush states
// reset: every voice free, tags and countdowns zero, channel map zero, mute ticks 8820
`default_nettype none

module polyphonic_voice_allocator #(
  parameter int NUM_VOICES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration port
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  // event channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [6:0]  note,
  input  wire logic [6:0]  velocity,
  input  wire logic [3:0]  channel,
  input  wire logic [31:0] tag,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       action,
  output logic [2:0]       voice,
  output logic [31:0]      voice_tag,
  output logic [6:0]       voice_note,
  output logic [6:0]       out_velocity,
  output logic             last
);
  import pva_pkg::*;

  localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

  // configuration registers
  logic [MAP_W-1:0]  chan_map;
  logic [MUTE_W-1:0] mute_ticks;

  // per-voice state
  logic [NUM_VOICES-1:0] busy;
  logic [NOTE_W-1:0]     held_note    [NUM_VOICES];
  logic [TAG_W-1:0]      age_tag      [NUM_VOICES];
  logic [MUTE_W-1:0]     release_left [NUM_VOICES];
  logic [TAG_W-1:0]      next_tag;

  // latched event
  kind_t              ev_kind;
  logic [NOTE_W-1:0]  ev_note;
  logic [VEL_W-1:0]   ev_vel;
  logic [CHAN_W-1:0]  ev_chan;
  logic [TAG_W-1:0]   ev_tag;

  // sequencer
  state_t            state, state_next;
  logic [IDX_W-1:0]  cnt;

  // note-on search results
  logic              have_free;
  logic [IDX_W-1:0]  free_idx;
  logic              have_old;
  logic [IDX_W-1:0]  old_idx;
  logic [TAG_W-1:0]  old_age;

  // release waiting for the next match (or the end) to know its last flag
  logic              have_pend;
  result_t           pend;

  // shared per-voice compare unit, looking at voice cnt
  logic [4:0]        map_shift;
  logic [CHAN_W-1:0] cur_chan;
  logic              chan_hit;
  logic              note_hit;
  logic              tag_hit;
  logic              older;
  logic              scan_end;
  logic [MUTE_W-1:0] mute_load;

  // controls
  logic     can_push;
  logic     push;
  result_t  push_res;
  logic     stall;
  logic     rel_here;
  logic     in_accept;

  assign map_shift = {3'(cnt), 2'b00};
  assign cur_chan  = CHAN_W'(chan_map >> map_shift);
  assign chan_hit  = (cur_chan == ev_chan);
  assign note_hit  = busy[cnt] && (held_note[cnt] == ev_note) && chan_hit;
  assign tag_hit   = busy[cnt] && (age_tag[cnt] == ev_tag);
  assign older     = !have_old || (age_tag[cnt] < old_age);
  assign scan_end  = (cnt == LAST_IDX);
  assign mute_load = (mute_ticks == '0) ? MUTE_W'(1) : mute_ticks;

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        case (ev_kind)
          KIND_NOTE_ON: begin
            if (scan_end) state_next = ST_COMMIT;
          end
          KIND_OFF_NOTE: begin
            if (!stall && scan_end) begin
              state_next = (have_pend || note_hit) ? ST_FLUSH : ST_IDLE;
            end
          end
          KIND_OFF_TAG: begin
            if (tag_hit) state_next = ST_FLUSH;
            else if (scan_end) state_next = ST_IDLE;
          end
          default: begin
            if (scan_end) state_next = ST_IDLE;
          end
        endcase
      end
      ST_COMMIT: begin
        if (can_push) state_next = ST_IDLE;
      end
      ST_FLUSH: begin
        if (can_push) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    push     = 1'b0;
    stall    = 1'b0;
    rel_here = 1'b0;
    push_res = pend;
    case (state)
      ST_SCAN: begin
        if (ev_kind == KIND_OFF_NOTE && note_hit) begin
          // an earlier release goes out now, marked as not the final one
          stall    = have_pend && !can_push;
          push     = have_pend && can_push;
          rel_here = !stall;
          push_res.last = 1'b0;
        end else if (ev_kind == KIND_OFF_TAG && tag_hit) begin
          rel_here = 1'b1;
        end
      end
      ST_COMMIT: begin
        push = can_push;
        push_res.note = ev_note;
        push_res.vel  = ev_vel;
        push_res.last = 1'b1;
        if (have_free || have_old) begin
          push_res.action = ACT_START;
          push_res.voice  = VOICE_W'(have_free ? free_idx : old_idx);
          push_res.tag    = next_tag;
        end else begin
          push_res.action = ACT_NONE;
          push_res.voice  = '0;
          push_res.tag    = '0;
        end
      end
      ST_FLUSH: begin
        push = can_push;
        push_res.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      chan_map   <= '0;
      mute_ticks <= MUTE_TICKS_RESET;
    end else begin
      state <= state_next;
      if (in_accept) begin
        cnt <= '0;
      end else if (state == ST_SCAN && !stall && !scan_end) begin
        cnt <= cnt + IDX_W'(1);
      end
      if (cfg_write) begin
        if (cfg_index == REG_CHANNEL_MAP) chan_map <= cfg_data;
        else mute_ticks <= MUTE_W'(cfg_data);
      end
    end
  end

  // latched event and search bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      have_free <= 1'b0;
      have_old  <= 1'b0;
      have_pend <= 1'b0;
    end else if (in_accept) begin
      have_free <= 1'b0;
      have_old  <= 1'b0;
      have_pend <= 1'b0;
    end else if (state == ST_SCAN) begin
      if (ev_kind == KIND_NOTE_ON && chan_hit) begin
        if (!busy[cnt] && !have_free) have_free <= 1'b1;
        if (older) have_old <= 1'b1;
      end
      if (rel_here) have_pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ev_kind <= kind_t'(kind);
      ev_note <= note;
      ev_vel  <= velocity;
      ev_chan <= channel;
      ev_tag  <= tag;
    end
    if (state == ST_SCAN && ev_kind == KIND_NOTE_ON && chan_hit) begin
      if (!busy[cnt] && !have_free) free_idx <= cnt;
      if (older) begin
        old_idx <= cnt;
        old_age <= age_tag[cnt];
      end
    end
    if (rel_here) begin
      pend.action <= ACT_RELEASE;
      pend.voice  <= VOICE_W'(cnt);
      pend.tag    <= age_tag[cnt];
      pend.note   <= held_note[cnt];
      pend.vel    <= ev_vel;
      pend.last   <= 1'b0;
    end
  end

  // per-voice state updates, one voice per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= '0;
      next_tag <= '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        age_tag[i]      <= '0;
        release_left[i] <= '0;
      end
    end else begin
      if (rel_here) begin
        release_left[cnt] <= mute_load;
      end
      if (state == ST_SCAN && ev_kind == KIND_TICK && release_left[cnt] != '0) begin
        release_left[cnt] <= release_left[cnt] - MUTE_W'(1);
        if (release_left[cnt] == MUTE_W'(1)) busy[cnt] <= 1'b0;
      end
      if (state == ST_COMMIT && can_push && (have_free || have_old)) begin
        age_tag[have_free ? free_idx : old_idx]      <= next_tag;
        release_left[have_free ? free_idx : old_idx] <= '0;
        busy[have_free ? free_idx : old_idx]         <= 1'b1;
        next_tag                                     <= next_tag + TAG_W'(1);
      end
    end
  end

  // note memory has no reset; only read while the voice is busy
  always_ff @(posedge clk) begin
    if (state == ST_COMMIT && can_push && (have_free || have_old)) begin
      held_note[have_free ? free_idx : old_idx] <= ev_note;
    end
  end

  pva_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_res     (push_res),
    .can_push     (can_push),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .voice        (voice),
    .voice_tag    (voice_tag),
    .voice_note   (voice_note),
    .out_velocity (out_velocity),
    .last         (last)
  );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for the polyphonic voice allocator
`timescale 1ns / 1ps

module tb;
  import pva_pkg::*;

  localparam int NUM_VOICES  = 8;
  localparam int STALL_MAX   = 7;
  // one event scans every voice and commits, plus margin
  localparam int SETTLE      = NUM_VOICES + 4;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 20;
  localparam int N_PHASES    = 5;
  localparam int MAX_SHOWN   = 10;
  localparam int DIR_N       = 23;

  // one note event; typed rows carry their own answer (or none at all)
  typedef struct packed {
    kind_t              kind;
    logic [NOTE_W-1:0]  note;
    logic [VEL_W-1:0]   vel;
    logic [CHAN_W-1:0]  chan;
    logic [TAG_W-1:0]   tag;
    logic               typed;
    logic               has_res;
    result_t            res;
  } note_event_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  initial begin
    forever #2 clk = ~clk;
  end

  // block inputs, all known from time zero
  logic              cfg_write = 1'b0;
  logic              cfg_index = REG_CHANNEL_MAP;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [1:0]        kind      = '0;
  logic [NOTE_W-1:0] note      = '0;
  logic [VEL_W-1:0]  velocity  = '0;
  logic [CHAN_W-1:0] channel   = '0;
  logic [TAG_W-1:0]  tag       = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        action;
  logic [2:0]        voice;
  logic [31:0]       voice_tag;
  logic [6:0]        voice_note;
  logic [6:0]        out_velocity;
  logic              last;

  polyphonic_voice_allocator #(
    .NUM_VOICES(NUM_VOICES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .note         (note),
    .velocity     (velocity),
    .channel      (channel),
    .tag          (tag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .action       (action),
    .voice        (voice),
    .voice_tag    (voice_tag),
    .voice_note   (voice_note),
    .out_velocity (out_velocity),
    .last         (last)
  );

  // ---------------------------------------------------------------------------
  // voice pool mirror: our own copy of the allocator state and registers
  // ---------------------------------------------------------------------------
  logic [MAP_W-1:0]  map_reg  = '0;
  logic [MUTE_W-1:0] mute_reg = MUTE_TICKS_RESET;
  logic              vbusy [NUM_VOICES] = '{default: 1'b0};
  logic [NOTE_W-1:0] vnote [NUM_VOICES] = '{default: '0};
  logic [TAG_W-1:0]  vtag  [NUM_VOICES] = '{default: '0};
  logic [MUTE_W-1:0] vleft [NUM_VOICES] = '{default: '0};
  logic [TAG_W-1:0]  tag_ctr = '0;

  // voice commands still owed by the block, oldest first
  result_t want_cmds [$];

  int  n_bad = 0;
  int  idle_cycles = 0;
  // when set, neither side inserts gaps or stalls
  bit  rush = 1'b0;

  function automatic logic [CHAN_W-1:0] voice_chan(input int v);
    return map_reg[4*v +: 4];
  endfunction

  // a zero register still holds the voice for one tick
  function automatic logic [MUTE_W-1:0] mute_load();
    return (mute_reg == '0) ? MUTE_W'(1) : mute_reg;
  endfunction

  // queue one more owed command at the tail
  function automatic void owe_cmd(input result_t c);
    want_cmds.insert(want_cmds.size(), c);
  endfunction

  // work out the commands one event causes and update the mirror
  task automatic allocate_voice_cmds(input note_event_t ev, input bit keep);
    result_t cmds [NUM_VOICES];
    int      n;
    int      pick;
    n    = 0;
    pick = -1;
    case (ev.kind)
      KIND_NOTE_ON: begin
        // lowest free voice of the channel first
        for (int v = 0; v < NUM_VOICES; v++)
          if (pick < 0 && !vbusy[v] && voice_chan(v) == ev.chan) pick = v;
        // otherwise steal the oldest tag, lowest index on a tie
        if (pick < 0)
          for (int v = 0; v < NUM_VOICES; v++)
            if (voice_chan(v) == ev.chan && (pick < 0 || vtag[v] < vtag[pick])) pick = v;
        if (pick < 0) begin
          cmds[0] = '{ACT_NONE, '0, '0, ev.note, ev.vel, 1'b0};
        end else begin
          vtag[pick]  = tag_ctr;
          tag_ctr     = tag_ctr + TAG_W'(1);
          vnote[pick] = ev.note;
          vbusy[pick] = 1'b1;
          vleft[pick] = '0;
          cmds[0] = '{ACT_START, VOICE_W'(pick), vtag[pick], ev.note, ev.vel, 1'b0};
        end
        n = 1;
      end
      KIND_OFF_NOTE: begin
        // every held voice of the channel on that note
        for (int v = 0; v < NUM_VOICES; v++)
          if (vbusy[v] && vnote[v] == ev.note && voice_chan(v) == ev.chan) begin
            vleft[v] = mute_load();
            cmds[n]  = '{ACT_RELEASE, VOICE_W'(v), vtag[v], vnote[v], ev.vel, 1'b0};
            n++;
          end
      end
      KIND_OFF_TAG: begin
        // first held voice with the tag only
        for (int v = 0; v < NUM_VOICES; v++)
          if (pick < 0 && vbusy[v] && vtag[v] == ev.tag) begin
            pick     = v;
            vleft[v] = mute_load();
            cmds[0]  = '{ACT_RELEASE, VOICE_W'(v), vtag[v], vnote[v], ev.vel, 1'b0};
            n        = 1;
          end
      end
      KIND_TICK: begin
        for (int v = 0; v < NUM_VOICES; v++)
          if (vleft[v] != '0) begin
            vleft[v] = vleft[v] - MUTE_W'(1);
            if (vleft[v] == '0) vbusy[v] = 1'b0;
          end
      end
      default: ;
    endcase
    if (n > 0) cmds[n-1].last = 1'b1;
    if (keep)
      for (int i = 0; i < n; i++) owe_cmd(cmds[i]);
  endtask

  // ---------------------------------------------------------------------------
  // event side: gap, present, hold until the transaction is taken
  // ---------------------------------------------------------------------------
  task automatic offer_event(input note_event_t ev);
    int gap;
    gap = rush ? 0 : $urandom_range(0, STALL_MAX);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= ev.kind;
    note     <= ev.note;
    velocity <= ev.vel;
    channel  <= ev.chan;
    tag      <= ev.tag;
    do @(posedge clk); while (!in_ready);
    // typed rows still move the mirror on, but their own answer is the one owed
    allocate_voice_cmds(ev, !ev.typed);
    if (ev.typed && ev.has_res) owe_cmd(ev.res);
  endtask

  // stop sending, let every owed command arrive, then let the scan finish
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (want_cmds.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_CHANNEL_MAP) map_reg = data[MAP_W-1:0];
    else mute_reg = data[MUTE_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // command side: random stall per transaction, then take it
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = rush ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // compare every accepted command with the oldest one owed
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{action_t'(action), voice, voice_tag, voice_note, out_velocity, last};
      if (want_cmds.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_SHOWN)
          $display("unexpected command: action %0d voice %0d tag %h note %0d vel %0d %s %0b",
                   got.action, got.voice, got.tag, got.note, got.vel, "last", got.last);
      end else begin
        want = want_cmds.pop_front();
        if (got.action !== want.action || got.voice !== want.voice ||
            got.tag !== want.tag || got.note !== want.note ||
            got.vel !== want.vel || got.last !== want.last) begin
          n_bad++;
          if (n_bad <= MAX_SHOWN) begin
            $display("command mismatch: expected action %0d voice %0d tag %h note %0d %s",
                     want.action, want.voice, want.tag, want.note, "vel/last");
            $display("  expected vel %0d last %0b", want.vel, want.last);
            $display("  got action %0d voice %0d tag %h note %0d vel %0d last %0b",
                     got.action, got.voice, got.tag, got.note, got.vel, got.last);
          end
        end
      end
    end
  end

  // watchdog: too long with no transaction on either side means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed events, run under the reset register values (all voices on channel 0)
  // ---------------------------------------------------------------------------
  note_event_t dir_rows [DIR_N] = '{
    // tag 0 matches only free voices straight after reset: nothing released
    '{KIND_OFF_TAG,  7'd0,   7'd0,   4'd0,  32'd0, 1'b1, 1'b0, '0},
    '{KIND_NOTE_ON,  7'd0,   7'd0,   4'd0,  32'd0, 1'b1, 1'b1,
      '{ACT_START, 3'd0, 32'd0, 7'd0, 7'd0, 1'b1}},
    '{KIND_NOTE_ON,  7'd127, 7'd127, 4'd0,  32'd0, 1'b1, 1'b1,
      '{ACT_START, 3'd1, 32'd1, 7'd127, 7'd127, 1'b1}},
    // no voice belongs to channel 15
    '{KIND_NOTE_ON,  7'd5,   7'd9,   4'd15, 32'd0, 1'b1, 1'b1,
      '{ACT_NONE, 3'd0, 32'd0, 7'd5, 7'd9, 1'b1}},
    // note-offs that match nothing
    '{KIND_OFF_NOTE, 7'd5,   7'd1,   4'd0,  32'd0, 1'b1, 1'b0, '0},
    '{KIND_OFF_NOTE, 7'd127, 7'd127, 4'd15, 32'd0, 1'b1, 1'b0, '0},
    '{KIND_OFF_TAG,  7'd0,   7'd3,   4'd0,  32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    // release by tag, then again while already releasing
    '{KIND_OFF_TAG,  7'd0,   7'd64,  4'd0,  32'd1, 1'b1, 1'b1,
      '{ACT_RELEASE, 3'd1, 32'd1, 7'd127, 7'd64, 1'b1}},
    '{KIND_OFF_TAG,  7'd0,   7'd65,  4'd0,  32'd1, 1'b1, 1'b1,
      '{ACT_RELEASE, 3'd1, 32'd1, 7'd127, 7'd65, 1'b1}},
    '{KIND_TICK,     7'd0,   7'd0,   4'd0,  32'd0, 1'b1, 1'b0, '0},
    // fill the rest of the pool on one note
    '{KIND_NOTE_ON,  7'd60,  7'd10,  4'd0,  32'd0, 1'b0, 1'b0, '0},
    '{KIND_NOTE_ON,  7'd60,  7'd20,  4'd0,  32'd0, 1'b0, 1'b0, '0},
    '{KIND_NOTE_ON,  7'd60,  7'd30,  4'd0,  32'd0, 1'b0, 1'b0, '0},
    '{KIND_NOTE_ON,  7'd60,  7'd40,  4'd0,  32'd0, 1'b0, 1'b0, '0},
    '{KIND_NOTE_ON,  7'd60,  7'd50,  4'd0,  32'd0, 1'b0, 1'b0, '0},
    '{KIND_NOTE_ON,  7'd60,  7'd70,  4'd0,  32'd0, 1'b0, 1'b0, '0},
    // pool full: steal the oldest, then the releasing one
    '{KIND_NOTE_ON,  7'd61,  7'd100, 4'd0,  32'd0, 1'b0, 1'b0, '0},
    '{KIND_NOTE_ON,  7'd62,  7'd101, 4'd0,  32'd0, 1'b0, 1'b0, '0},
    // one note-off releasing six voices, then reloading them all
    '{KIND_OFF_NOTE, 7'd60,  7'd11,  4'd0,  32'd0, 1'b0, 1'b0, '0},
    '{KIND_OFF_NOTE, 7'd60,  7'd12,  4'd0,  32'd0, 1'b0, 1'b0, '0},
    '{KIND_OFF_TAG,  7'd0,   7'd13,  4'd0,  32'd8, 1'b0, 1'b0, '0},
    '{KIND_TICK,     7'd127, 7'd127, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
    // steal while every voice but voice 1 is releasing
    '{KIND_NOTE_ON,  7'd127, 7'd1,   4'd0,  32'd0, 1'b0, 1'b0, '0}
  };

  // register values per random phase; the fourth is drawn at run time
  logic [31:0] phase_map  [N_PHASES] =
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7654_3210, 32'h0000_0000, 32'h1111_0000};
  // zero mute and junk above bit 23 are both part of the plan
  logic [31:0] phase_mute [N_PHASES] =
    '{32'd3, 32'd0, 32'h00FF_FFFF, 32'd0, 32'hFF00_0002};

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    note_event_t ev;
    int          r;
    int          v;
    logic [31:0] map_word;
    logic [31:0] mute_word;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer_event(dir_rows[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      map_word  = phase_map[ph];
      mute_word = phase_mute[ph];
      if (ph == 3) begin
        map_word  = $urandom;
        mute_word = {8'($urandom_range(0, 255)), 24'($urandom_range(1, 6))};
      end
      quiesce();
      write_reg(REG_CHANNEL_MAP, map_word);
      write_reg(REG_MUTE_TICKS, mute_word);
      // one phase runs flat out on both sides
      rush = (ph == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // mid-phase the sender waits for the pipeline to empty
        if (i == PHASE_ITEMS / 2) quiesce();
        ev       = '0;
        ev.vel   = 7'($urandom_range(0, 127));
        ev.tag   = $urandom;
        v        = $urandom_range(0, NUM_VOICES - 1);
        // mostly channels that own a voice, so allocation gets exercised
        ev.chan  = ($urandom_range(0, 99) < 85) ? voice_chan(v) : 4'($urandom_range(0, 15));
        // a narrow note range makes shared notes and multi-voice releases common
        ev.note  = ($urandom_range(0, 99) < 70) ? 7'(60 + $urandom_range(0, 3))
                                                : 7'($urandom_range(0, 127));
        r = $urandom_range(0, 99);
        if (r < 40) begin
          ev.kind = KIND_NOTE_ON;
        end else if (r < 65) begin
          ev.kind = KIND_OFF_NOTE;
          if (vbusy[v] && $urandom_range(0, 3) != 0) begin
            ev.note = vnote[v];
            ev.chan = voice_chan(v);
          end
        end else if (r < 80) begin
          ev.kind = KIND_OFF_TAG;
          if ($urandom_range(0, 3) != 0) ev.tag = vtag[v];
        end else begin
          ev.kind = KIND_TICK;
        end
        offer_event(ev);
      end
      rush = 1'b0;
    end

    quiesce();
    if (n_bad == 0 && want_cmds.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
